>>> sv/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types and constants for the piezo hit detector.
// ----------------------------------------------------------------------------
package phd_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned VEL_W      = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_THRESHOLD = 3'd0,
		REG_WINDOW_US      = 3'd1,
		REG_VELOCITY_SHIFT = 3'd2,
		REG_DECAY_SHIFT    = 3'd3,
		REG_GAIN_TENTHS    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [9:0]  base_threshold;
		logic [15:0] window_us;
		logic [2:0]  velocity_shift;
		logic [4:0]  decay_shift;
		logic [5:0]  gain_tenths;
	} cfg_t;

	localparam logic [9:0]  RST_BASE_THRESHOLD = 10'd10;
	localparam logic [15:0] RST_WINDOW_US      = 16'd500;
	localparam logic [2:0]  RST_VELOCITY_SHIFT = 3'd2;
	localparam logic [4:0]  RST_DECAY_SHIFT    = 5'd14;
	localparam logic [5:0]  RST_GAIN_TENTHS    = 6'd17;

	// floor(x / 10) <= v  <=>  x <= 10 * v + 9
	localparam int unsigned TENTH_SLACK = 9;

	localparam logic [VEL_W-1:0] VEL_MAX = 9'd511;

	typedef struct packed {
		logic clear_recent;
		logic start_hit;
	} rt_t;

endpackage

>>> sv/phd_cfg_regs.sv
// ----------------------------------------------------------------------------
// phd_cfg_regs
// Configuration register file, written through the cfg request channel.
// ----------------------------------------------------------------------------
module phd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [phd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [phd_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                cfg_ready,
	output phd_pkg::cfg_t                       cfg
);
	import phd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_threshold <= RST_BASE_THRESHOLD;
			cfg_q.window_us      <= RST_WINDOW_US;
			cfg_q.velocity_shift <= RST_VELOCITY_SHIFT;
			cfg_q.decay_shift    <= RST_DECAY_SHIFT;
			cfg_q.gain_tenths    <= RST_GAIN_TENTHS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_THRESHOLD: cfg_q.base_threshold <= cfg_data[9:0];
				REG_WINDOW_US:      cfg_q.window_us      <= cfg_data[15:0];
				REG_VELOCITY_SHIFT: cfg_q.velocity_shift <= cfg_data[2:0];
				REG_DECAY_SHIFT:    cfg_q.decay_shift    <= cfg_data[4:0];
				REG_GAIN_TENTHS:    cfg_q.gain_tenths    <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

endmodule

>>> sv/phd_retrigger.sv
// ----------------------------------------------------------------------------
// phd_retrigger
// Idle-side threshold decision: decaying retrigger level against the base
// threshold and the incoming sample, compared in tenths to avoid a divide.
// ----------------------------------------------------------------------------
module phd_retrigger #(
	parameter int unsigned ADC_BITS = 10
) (
	input  logic                  recent_hit,
	input  logic [ADC_BITS-1:0]   sample,
	input  logic [31:0]           timestamp,
	input  logic [ADC_BITS-1:0]   peak_value,
	input  logic [31:0]           peak_time,
	input  phd_pkg::cfg_t         cfg,
	output phd_pkg::rt_t          rt
);
	import phd_pkg::*;

	localparam int unsigned W   = ADC_BITS + 6;
	localparam int unsigned SHW = $clog2(ADC_BITS);

	logic [31:0]         elapsed;
	logic [31:0]         halvings;
	logic                decayed_out;
	logic [ADC_BITS-1:0] shifted;
	logic [W-1:0]        level_x10;
	logic [W-1:0]        base_w;
	logic [W-1:0]        sample_w;
	logic [W-1:0]        base_lim;
	logic [W-1:0]        sample_lim;
	logic                below_base;
	logic                above_base;
	logic                above_level;

	always_comb begin
		elapsed     = timestamp - peak_time;
		halvings    = elapsed >> cfg.decay_shift;
		decayed_out = halvings >= 32'(ADC_BITS);
		shifted     = decayed_out ? '0 : (peak_value >> halvings[SHW-1:0]);
		level_x10   = W'(shifted) * W'(cfg.gain_tenths);

		base_w      = W'(cfg.base_threshold);
		sample_w    = W'(sample);
		base_lim    = (base_w << 3) + (base_w << 1) + W'(TENTH_SLACK);
		sample_lim  = (sample_w << 3) + (sample_w << 1) + W'(TENTH_SLACK);

		below_base  = level_x10 <= base_lim;
		above_base  = sample_w >= base_w;
		above_level = level_x10 <= sample_lim;

		rt.clear_recent = recent_hit && below_base;
		rt.start_hit    = (recent_hit && !below_base) ? above_level : above_base;
	end

endmodule

>>> sv/piezo_hit_detector.sv
// ----------------------------------------------------------------------------
// piezo_hit_detector
// Drum trigger peak detector with a decaying retrigger mask.
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------
//   sample  | sample_valid/sample_stall| sample, timestamp
//   hit     | hit_valid/hit_stall      | velocity, peak_level
//   cfg     | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// One sample per cycle while sample_stall is low. A sample is registered in the
// input register, then decided against the window and threshold state; a hit
// appears in the result register in the cycle after that decision.
// Samples that end a window wait only while the hit register is full and
// stalled; all other samples pass regardless of hit_stall.
// Reset clears control state and restores register defaults.
// ----------------------------------------------------------------------------
module piezo_hit_detector #(
	parameter int unsigned ADC_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [ADC_BITS-1:0]                sample,
	input  logic [31:0]                        timestamp,
	output logic                               hit_valid,
	input  logic                               hit_stall,
	output logic [phd_pkg::VEL_W-1:0]          velocity,
	output logic [ADC_BITS-1:0]                peak_level,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [phd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [phd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import phd_pkg::*;

	localparam int unsigned VW = ADC_BITS + 1;

	cfg_t cfg;
	rt_t  rt;

	logic                valid_s1;
	logic [ADC_BITS-1:0] sample_s1;
	logic [31:0]         timestamp_s1;

	logic [ADC_BITS-1:0] peak_q;
	logic [31:0]         peak_time_q;
	logic [31:0]         window_start_q;
	logic                recent_q;
	logic                capturing_q;

	logic                hit_valid_q;
	logic [VEL_W-1:0]    velocity_q;
	logic [ADC_BITS-1:0] peak_level_q;

	logic [31:0]         win_diff;
	logic                in_window;
	logic                emit;
	logic                out_free;
	logic                adv;
	logic                accept;
	logic [VW-1:0]       vel_raw;
	logic [VEL_W-1:0]    vel_sat;

	phd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	phd_retrigger #(
		.ADC_BITS (ADC_BITS)
	) u_rt (
		.recent_hit (recent_q),
		.sample     (sample_s1),
		.timestamp  (timestamp_s1),
		.peak_value (peak_q),
		.peak_time  (peak_time_q),
		.cfg        (cfg),
		.rt         (rt)
	);

	always_comb begin
		win_diff     = window_start_q + {16'd0, cfg.window_us} - timestamp_s1;
		in_window    = !win_diff[31];
		emit         = capturing_q && !in_window;
		out_free     = !hit_valid_q || !hit_stall;
		adv          = valid_s1 && (!emit || out_free);
		sample_stall = valid_s1 && !adv;
		accept       = sample_valid && !sample_stall;
		vel_raw      = VW'(peak_q >> cfg.velocity_shift) + VW'(1);
		vel_sat      = (vel_raw > VW'(VEL_MAX)) ? VEL_MAX : vel_raw[VEL_W-1:0];
	end

	assign hit_valid  = hit_valid_q;
	assign velocity   = velocity_q;
	assign peak_level = peak_level_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1    <= sample;
			timestamp_s1 <= timestamp;
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q         <= '0;
			peak_time_q    <= '0;
			window_start_q <= '0;
			recent_q       <= 1'b0;
			capturing_q    <= 1'b0;
		end else if (adv) begin
			if (capturing_q) begin
				if (in_window) begin
					if (sample_s1 > peak_q) begin
						peak_q      <= sample_s1;
						peak_time_q <= timestamp_s1;
					end
				end else begin
					capturing_q <= 1'b0;
					recent_q    <= 1'b1;
				end
			end else begin
				if (rt.clear_recent) begin
					recent_q <= 1'b0;
				end
				if (rt.start_hit) begin
					capturing_q    <= 1'b1;
					window_start_q <= timestamp_s1;
					peak_q         <= sample_s1;
					if (sample_s1 != '0) begin
						peak_time_q <= timestamp_s1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_q <= 1'b0;
		end else if (adv && emit) begin
			hit_valid_q <= 1'b1;
		end else if (!hit_stall) begin
			hit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			velocity_q   <= vel_sat;
			peak_level_q <= peak_q;
		end
	end

	a_vel_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid_q |-> velocity_q != '0)
		else $error("hit with zero velocity");

	a_emit_ends_capture: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> !capturing_q && recent_q && hit_valid_q)
		else $error("window end did not close capture");

	a_peak_grows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && capturing_q && !emit |=> peak_q >= $past(peak_q))
		else $error("peak dropped inside window");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && emit && hit_valid_q)
		else $error("sample stalled without a blocked hit");

endmodule
